FILE: src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the Huffman code bit packer
// Table geometry, field widths, code length cap and the mode codes.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int unsigned SymW       = 8;
  localparam int unsigned TableDepth = 1 << SymW;
  localparam int unsigned CodeW      = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PendW      = ByteW - 1;
  localparam int unsigned CntW       = 3;
  localparam int unsigned AccW       = CodeW + PendW;

  // Longest code the table keeps; loads above it saturate
  localparam int unsigned MaxCodeLen = 32;
  localparam int unsigned CapLen     = (MaxCodeLen < CodeW) ? MaxCodeLen : CodeW;

  typedef enum logic [1:0] {
    ModeLoad   = 2'd0,
    ModeEncode = 2'd1,
    ModeFlush  = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  // One table entry: right-aligned code and its length
  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [LenW-1:0]  len;
  } entry_t;

endpackage

FILE: src/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: table-driven Huffman encoder with byte packer
// An accepted item is registered in the lookup stage, then in the byte buffer.
// Throughput: one item per cycle while each item yields at most one byte and
// out_stall_i is low; more bytes (max 4) hold the output until all are taken.
// Reset: code table valid bits, bit accumulator and all handshake state clear;
// table RAM contents are not reset (an entry without a valid bit reads absent).
// ----------------------------------------------------------------------------
module huffman_code_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  symbol_i,
  input  logic [31:0] code_bits_i,
  input  logic [5:0]  code_length_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o
);

  localparam int unsigned CodeW = hcbp_pkg::CodeW;
  localparam int unsigned LenW  = hcbp_pkg::LenW;
  localparam int unsigned AccW  = hcbp_pkg::AccW;
  localparam int unsigned PendW = hcbp_pkg::PendW;
  localparam int unsigned CntW  = hcbp_pkg::CntW;
  localparam int unsigned ByteW = hcbp_pkg::ByteW;
  localparam int unsigned BufW  = 4 * ByteW;

  // Code table storage and its per-entry valid bits
  hcbp_pkg::entry_t                       code_mem [hcbp_pkg::TableDepth];
  logic [hcbp_pkg::TableDepth-1:0]        entry_vld_q;

  hcbp_pkg::mode_e  in_mode;
  logic             in_acc;
  logic [LenW-1:0]  len_cap;
  logic [CodeW:0]   len_mask;
  hcbp_pkg::entry_t wr_entry;

  // Lookup stage
  logic              s1_vld_q;
  hcbp_pkg::mode_e   s1_mode_q;
  hcbp_pkg::entry_t  rd_entry_q;
  logic              rd_vld_q;
  logic              s1_go;

  // Accumulator
  logic [PendW-1:0]  pend_bits_q, pend_bits_d;
  logic [CntW-1:0]   pend_cnt_q, pend_cnt_d;

  // Byte serialiser
  logic [BufW-1:0]   buf_q, buf_d;
  logic [CntW-1:0]   ser_cnt_q, ser_cnt_d;
  logic              ser_free;
  logic              out_acc;

  // Encode datapath
  logic [CodeW-1:0]  eff_code;
  logic [LenW-1:0]   eff_len;
  logic [AccW-1:0]   acc;
  logic [LenW-1:0]   total;
  logic [CntW-1:0]   rem;
  logic [CntW-1:0]   nbytes;
  logic [AccW-1:0]   acc_sh;
  logic [BufW-1:0]   enc_buf;
  logic [PendW:0]    rem_mask;
  logic [ByteW-1:0]  flush_byte;

  // Handshake
  assign in_mode  = hcbp_pkg::mode_e'(mode_i);
  assign ser_free = (ser_cnt_q == '0) || ((ser_cnt_q == CntW'(1)) && !out_stall_i);
  assign s1_go    = s1_vld_q && ser_free;
  assign in_stall_o = s1_vld_q && !ser_free;
  assign in_acc   = in_valid_i && !in_stall_o;

  assign out_valid_o = (ser_cnt_q != '0);
  assign out_byte_o  = buf_q[BufW-1 -: ByteW];
  assign last_o      = (ser_cnt_q == CntW'(1));
  assign out_acc     = out_valid_o && !out_stall_i;

  // Load: saturate the length and drop code bits above it
  assign len_cap  = (code_length_i > LenW'(hcbp_pkg::CapLen)) ?
                    LenW'(hcbp_pkg::CapLen) : code_length_i;
  assign len_mask = ((CodeW+1)'(1) << len_cap) - (CodeW+1)'(1);
  assign wr_entry.code = code_bits_i & len_mask[CodeW-1:0];
  assign wr_entry.len  = len_cap;

  // Table write port and registered read port
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_mode == hcbp_pkg::ModeLoad)) begin
      code_mem[symbol_i] <= wr_entry;
    end
    if (in_acc) begin
      rd_entry_q <= code_mem[symbol_i];
      s1_mode_q  <= in_mode;
    end
  end

  // Valid bits: an entry never loaded reads as absent
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else if (in_acc) begin
      rd_vld_q <= entry_vld_q[symbol_i];
      if (in_mode == hcbp_pkg::ModeLoad) begin
        entry_vld_q[symbol_i] <= 1'b1;
      end
    end
  end

  // Lookup stage occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc || s1_go) begin
      s1_vld_q <= in_acc;
    end
  end

  // Encode: append the code to the pending bits, split off whole bytes
  assign eff_code = rd_vld_q ? rd_entry_q.code : '0;
  assign eff_len  = rd_vld_q ? rd_entry_q.len  : '0;
  assign acc      = (AccW'(pend_bits_q) << eff_len) | AccW'(eff_code);
  assign total    = LenW'(pend_cnt_q) + eff_len;
  assign rem      = total[CntW-1:0];
  assign nbytes   = total[LenW-1:CntW];
  assign acc_sh   = acc >> rem;
  assign enc_buf  = acc_sh[BufW-1:0] << {CntW'(3'd4) - nbytes, 3'b000};
  assign rem_mask = ((PendW+1)'(1) << rem) - (PendW+1)'(1);

  // Flush: left-align the partial byte, zeros below
  assign flush_byte = ByteW'({1'b0, pend_bits_q} << (CntW'(0) - pend_cnt_q));

  // Next accumulator and serialiser state
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    buf_d       = buf_q;
    ser_cnt_d   = ser_cnt_q;
    if (out_acc) begin
      buf_d     = buf_q << ByteW;
      ser_cnt_d = ser_cnt_q - CntW'(1);
    end
    if (s1_go) begin
      case (s1_mode_q)
        hcbp_pkg::ModeEncode: begin
          buf_d       = enc_buf;
          ser_cnt_d   = nbytes;
          pend_bits_d = acc[PendW-1:0] & rem_mask[PendW-1:0];
          pend_cnt_d  = rem;
        end
        hcbp_pkg::ModeFlush: begin
          buf_d       = {flush_byte, {(BufW-ByteW){1'b0}}};
          ser_cnt_d   = (pend_cnt_q != '0) ? CntW'(1) : '0;
          pend_bits_d = '0;
          pend_cnt_d  = '0;
        end
        default: begin
          ser_cnt_d = '0;
        end
      endcase
    end
  end

  // Accumulator and serialiser control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      ser_cnt_q   <= '0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      ser_cnt_q   <= ser_cnt_d;
    end
  end

  // Byte buffer payload
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

`ifndef ASSERT_OFF
  // At most four bytes queued per transaction
  a_ser_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_cnt_q <= CntW'(4))
    else $error("serialiser holds more than four bytes");

  // Input only stalls while the lookup stage is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_vld_q)
    else $error("input stalled with empty lookup stage");

  // A flush leaves the accumulator empty
  a_flush_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && (s1_mode_q == hcbp_pkg::ModeFlush)) |=> (pend_cnt_q == '0))
    else $error("accumulator not cleared by flush");

  // After the final byte is taken, output drops unless a new item loads
  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o && !s1_go) |=> !out_valid_o)
    else $error("output still valid after final byte");
`endif

endmodule
